// File: design/slotalloc_pkg.sv
package slotalloc_pkg;

	// field widths fixed by the request/response format
	localparam int REQ_TYPE_W = 1;
	localparam int GROUP_W    = 3;
	localparam int SLOT_W     = 4;
	localparam int HEIGHT_W   = 16;
	localparam int POS_W      = 32;
	// fill count spans 0 .. 2*SLOTS-1 for SLOTS up to 16
	localparam int CNT_W      = 5;
	localparam int ENTRY_W    = HEIGHT_W + 3 * POS_W;

	// request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC   = 1'b0;
	localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 1'b1;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [GROUP_W-1:0]    group;
		logic [SLOT_W-1:0]     release_slot;
		logic [HEIGHT_W-1:0]   height_value;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} req_t;

	typedef struct packed {
		logic              stored;
		logic [SLOT_W-1:0] slot_used;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming request beat
		logic exec;     // update count/mask, write entry, load response
	} cmd_t;

endpackage

// File: design/slotalloc_if.sv
interface slotalloc_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/slotalloc_ram.sv
module slotalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [WIDTH-1:0]        wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/slotalloc_ctrl.sv
module slotalloc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output slotalloc_pkg::cmd_t cmd
);
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   exec_ok;

	// execute once the response register is free or drains this cycle
	assign exec_ok     = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign cmd.capture = req_valid && (state_q == S_IDLE);
	assign cmd.exec    = exec_ok;

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (exec_ok) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: design/slotalloc_dp.sv
module slotalloc_dp #(
	parameter int GROUPS = 8,
	parameter int SLOTS  = 10,
	localparam int AW = (GROUPS * SLOTS > 1) ? $clog2(GROUPS * SLOTS) : 1
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  slotalloc_pkg::cmd_t                     cmd,
	input  slotalloc_pkg::req_t                     req_data,
	output slotalloc_pkg::rsp_t                     rsp_data,
	output logic                                    ram_we,
	output logic [AW-1:0]                           ram_waddr,
	output logic [slotalloc_pkg::ENTRY_W-1:0]       ram_wdata
);
	localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GXW = (GW > slotalloc_pkg::GROUP_W) ? GW : slotalloc_pkg::GROUP_W;
	localparam logic [slotalloc_pkg::CNT_W-1:0] CNT_SLOTS = slotalloc_pkg::CNT_W'(SLOTS);
	localparam logic [slotalloc_pkg::CNT_W-1:0] CNT_LAST  = slotalloc_pkg::CNT_W'(2 * SLOTS - 1);

	slotalloc_pkg::req_t req_q;
	slotalloc_pkg::rsp_t rsp_q;
	logic [slotalloc_pkg::CNT_W-1:0] cnt_q  [GROUPS];
	logic [SLOTS-1:0]                mask_q [GROUPS];

	logic [GXW-1:0]                  gx;
	logic [GW-1:0]                   gi;
	logic                            g_ok;
	logic [slotalloc_pkg::CNT_W-1:0] cnt, cnt_inc, cnt_ring;
	logic [SLOTS-1:0]                mask;
	logic                            found;
	logic [slotalloc_pkg::SLOT_W-1:0] free_slot, ring_slot, wr_slot;
	logic                            is_alloc, below, do_write;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
	end

	// group lookup
	assign gx   = GXW'(req_q.group);
	assign gi   = gx[GW-1:0];
	assign g_ok = 32'(req_q.group) < GROUPS;
	assign cnt  = cnt_q[gi];
	assign mask = mask_q[gi];
	assign is_alloc = (req_q.req_type == slotalloc_pkg::REQ_ALLOC);
	assign below    = (cnt < CNT_SLOTS);

	// lowest clear bit below the raised count
	assign cnt_inc = cnt + 1'b1;
	always_comb begin
		found     = 1'b0;
		free_slot = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && (slotalloc_pkg::CNT_W'(i) < cnt_inc) && !mask[i]) begin
				found     = 1'b1;
				free_slot = slotalloc_pkg::SLOT_W'(i);
			end
		end
	end

	// ring step once full
	assign cnt_ring  = (cnt >= CNT_LAST) ? CNT_SLOTS : cnt_inc;
	assign ring_slot = slotalloc_pkg::SLOT_W'(cnt_ring - CNT_SLOTS);

	assign wr_slot  = below ? free_slot : ring_slot;
	assign do_write = g_ok && is_alloc && (!below || found);

	// entry write
	assign ram_we    = cmd.exec && do_write;
	assign ram_waddr = AW'(32'(gi) * SLOTS + 32'(wr_slot));
	assign ram_wdata = {req_q.height_value, req_q.pos_x, req_q.pos_y, req_q.pos_z};

	// per-group count and mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				cnt_q[g]  <= '0;
				mask_q[g] <= '0;
			end
		end else if (cmd.exec && g_ok) begin
			if (!is_alloc) begin
				if (32'(req_q.release_slot) < SLOTS) begin
					mask_q[gi][req_q.release_slot] <= 1'b0;
				end
			end else if (below) begin
				cnt_q[gi] <= cnt_inc;
				if (found) begin
					mask_q[gi][free_slot] <= 1'b1;
				end
			end else begin
				cnt_q[gi] <= cnt_ring;
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.stored    <= do_write;
			rsp_q.slot_used <= do_write ? wr_slot : '0;
		end
	end

	assign rsp_data = rsp_q;
endmodule

// File: design/slot_allocator_with_ring_overflow.sv
// channel  dir  payload                                          beat when
// req      in   req_type group release_slot height_value pos_*   valid && ready
// rsp      out  stored slot_used                                 valid && ready
//
// Each request is captured in the idle state; the execute state then does the
// read-modify-write of the group's count and mask and the entry store write.
// The response sits in an output register; a stalled response holds the
// controller in its execute state, and ready drops until it drains.
// Reset clears all fill counts and used masks at once; no clearing pass.
module slot_allocator_with_ring_overflow #(
	parameter int GROUPS = 8,
	parameter int SLOTS  = 10
) (
	input logic clk,
	input logic arst_n,
	slotalloc_if.sink   req,
	slotalloc_if.source rsp
);
	localparam int AW = (GROUPS * SLOTS > 1) ? $clog2(GROUPS * SLOTS) : 1;

	slotalloc_pkg::cmd_t                cmd;
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic [slotalloc_pkg::ENTRY_W-1:0]  ram_wdata;

	slotalloc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	slotalloc_dp #(
		.GROUPS (GROUPS),
		.SLOTS  (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req.data),
		.rsp_data  (rsp.data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	// entry store: height and three position words per slot
	slotalloc_ram #(
		.WIDTH (slotalloc_pkg::ENTRY_W),
		.DEPTH (GROUPS * SLOTS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (1'b0),
		.raddr ('0),
		.rdata ()
	);
endmodule
